// ===== hw/rtl/dpsu_pkg.sv =====
// Package for the demand paging swap unit: sizes, payload structs, FSM states,
// and the controller/datapath command and status structs. No dependencies.
`default_nettype none
package dpsu_pkg;
    localparam int VIRT_PAGES  = 8;
    localparam int PHYS_FRAMES = 4;
    localparam int PAGE_WORDS  = 8;
    localparam int DATA_BITS   = 32;
    localparam int PG_BITS  = $clog2(VIRT_PAGES);
    localparam int FR_BITS  = $clog2(PHYS_FRAMES);
    localparam int OFF_BITS = $clog2(PAGE_WORDS);
    localparam int BS_DEPTH = VIRT_PAGES * PAGE_WORDS;
    localparam int FS_DEPTH = PHYS_FRAMES * PAGE_WORDS;
    localparam int BS_ABITS = $clog2(BS_DEPTH);
    localparam int FS_ABITS = $clog2(FS_DEPTH);

    typedef struct packed {
        logic               func;
        logic [5:0]         virt_addr;
        logic signed [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic               page_fault;
        logic [1:0]         frame_used;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_LOOK, ST_SRCH, ST_PICK, ST_WB_RD, ST_WB_WR,
        ST_LD_RD, ST_LD_WR, ST_ACC, ST_RDW, ST_OUT
    } t_state;

    typedef struct packed {
        logic               clr;       // clearing pass, one RAM word each
        logic               take;      // latch input item
        logic               bump;      // access_count++
        logic               srch_clr;  // reset search
        logic               srch_step; // one search step
        logic               pick;      // fix victim / fill frame
        logic               wb_rd;     // read frame word for writeback
        logic               wb_wr;     // write backing word
        logic               ld_rd;     // read backing word
        logic               ld_wr;     // write frame word
        logic               map;       // update page table / stamps / counters
        logic               access;    // do the read/write access
        logic               keep_word; // hold the accessed word
        logic               capture;   // set output register
        logic               out_pop;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic hit;
        logic srch_done;
        logic has_owner;
        logic word_last;
    } t_sts;
endpackage
`default_nettype wire

// ===== hw/rtl/dpsu_ram.sv =====
// Generic single-port RAM with registered read.
// No package dependencies.
`default_nettype none
module dpsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/dpsu_ctrl.sv =====
// Controller FSM for the swap unit: sequences lookup, victim search,
// writeback and page load. Uses dpsu_pkg.
`default_nettype none
module dpsu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire dpsu_pkg::t_sts i_sts,
    output dpsu_pkg::t_cmd     o_cmd
);
    dpsu_pkg::t_state r_state, n_state;
    logic r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpsu_pkg::ST_CLR;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // result register frees once taken; new item waits only until it can land
    always_comb begin
        n_state = r_state;
        case (r_state)
            dpsu_pkg::ST_CLR:   if (i_sts.clr_done) n_state = dpsu_pkg::ST_IDLE;
            dpsu_pkg::ST_IDLE:  if (i_in_valid) n_state = dpsu_pkg::ST_LOOK;
            dpsu_pkg::ST_LOOK:  n_state = i_sts.hit ? dpsu_pkg::ST_ACC : dpsu_pkg::ST_SRCH;
            dpsu_pkg::ST_SRCH:  if (i_sts.srch_done) n_state = dpsu_pkg::ST_PICK;
            dpsu_pkg::ST_PICK:  n_state = i_sts.has_owner ? dpsu_pkg::ST_WB_RD
                                                          : dpsu_pkg::ST_LD_RD;
            dpsu_pkg::ST_WB_RD: n_state = dpsu_pkg::ST_WB_WR;
            dpsu_pkg::ST_WB_WR: n_state = i_sts.word_last ? dpsu_pkg::ST_LD_RD
                                                          : dpsu_pkg::ST_WB_RD;
            dpsu_pkg::ST_LD_RD: n_state = dpsu_pkg::ST_LD_WR;
            dpsu_pkg::ST_LD_WR: n_state = i_sts.word_last ? dpsu_pkg::ST_ACC
                                                          : dpsu_pkg::ST_LD_RD;
            dpsu_pkg::ST_ACC:   n_state = dpsu_pkg::ST_RDW;
            dpsu_pkg::ST_RDW:   n_state = dpsu_pkg::ST_OUT;
            dpsu_pkg::ST_OUT:   if (!r_ov || i_out_ready) n_state = dpsu_pkg::ST_IDLE;
            default:            n_state = dpsu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        n_ov  = r_ov;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        o_cmd.out_pop = r_ov && i_out_ready;
        case (r_state)
            dpsu_pkg::ST_CLR:   o_cmd.clr = 1'b1;
            dpsu_pkg::ST_IDLE:  begin
                o_cmd.take = i_in_valid;
                o_cmd.bump = i_in_valid;
            end
            dpsu_pkg::ST_LOOK:  o_cmd.srch_clr = 1'b1;
            dpsu_pkg::ST_SRCH:  o_cmd.srch_step = 1'b1;
            dpsu_pkg::ST_PICK:  o_cmd.pick = 1'b1;
            dpsu_pkg::ST_WB_RD: o_cmd.wb_rd = 1'b1;
            dpsu_pkg::ST_WB_WR: o_cmd.wb_wr = 1'b1;
            dpsu_pkg::ST_LD_RD: o_cmd.ld_rd = 1'b1;
            dpsu_pkg::ST_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
                o_cmd.map   = i_sts.word_last;
            end
            dpsu_pkg::ST_ACC:   o_cmd.access = 1'b1;
            dpsu_pkg::ST_RDW:   o_cmd.keep_word = 1'b1;
            dpsu_pkg::ST_OUT:   begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.capture = 1'b1;
                    n_ov = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_in_ready  = (r_state == dpsu_pkg::ST_IDLE);
    assign o_out_valid = r_ov;
endmodule
`default_nettype wire

// ===== hw/rtl/dpsu_dp.sv =====
// Datapath for the swap unit: page table, frame counters and stamps,
// victim search, backing/frame RAMs. Uses dpsu_pkg and dpsu_ram.
`default_nettype none
module dpsu_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_data,
    input  wire dpsu_pkg::t_in_item i_item,
    input  wire dpsu_pkg::t_cmd     i_cmd,
    output dpsu_pkg::t_sts          o_sts,
    output dpsu_pkg::t_out_item     o_item
);
    localparam int PG = dpsu_pkg::PG_BITS;
    localparam int FR = dpsu_pkg::FR_BITS;
    localparam int OF = dpsu_pkg::OFF_BITS;
    localparam int DB = dpsu_pkg::DATA_BITS;
    localparam int NP = dpsu_pkg::VIRT_PAGES;
    localparam int NF = dpsu_pkg::PHYS_FRAMES;
    localparam int BA = dpsu_pkg::BS_ABITS;
    localparam int FA = dpsu_pkg::FS_ABITS;
    // search walks frames then pages; one index wide enough for both
    localparam int SI = $clog2(NP + NF + 1);
    localparam int PAGE_LAST = dpsu_pkg::PAGE_WORDS - 1;

    logic              r_mode;
    logic              r_func;
    logic [PG-1:0]     r_page;
    logic [OF-1:0]     r_off;
    logic [DB-1:0]     r_wdata;
    logic [31:0]       r_acc;
    logic [NP-1:0]     r_valid, r_dirty;
    logic [PG-1:0]     r_pframe [NP];
    logic [31:0]       r_cnt [NF];
    logic [31:0]       r_stamp [NF];
    logic [BA-1:0]     r_clr;
    // search state
    logic [SI-1:0]     r_si;
    logic              r_empty_found;
    logic [FR-1:0]     r_efr;
    logic [FR-1:0]     r_vfr;
    logic [31:0]       r_best;
    logic              r_found;
    logic [PG-1:0]     r_owner;
    logic              r_has_owner;
    logic [FR-1:0]     r_frame;
    logic [OF-1:0]     r_w;
    logic              r_fault;
    logic [DB-1:0]     r_res;
    dpsu_pkg::t_out_item r_out;

    logic [DB-1:0] bs_rd, fs_rd, bs_wd, fs_wd;
    logic          bs_we, fs_we;
    logic [BA-1:0] bs_a;
    logic [FA-1:0] fs_a;
    logic [PG-1:0] pg_frame_cur;
    logic [FR-1:0] safe_cur;
    logic [PG-1:0] s_pg;
    logic [FR-1:0] s_fr;
    logic [FR-1:0] safe_s;
    logic [31:0]   s_cnt;
    logic          in_frames;
    logic [FR-1:0] safe_s_owner;

    assign pg_frame_cur = r_pframe[r_page];
    assign safe_cur = (32'(pg_frame_cur) < NF) ? FR'(pg_frame_cur) : '0;
    assign in_frames = (r_si < SI'(NF));
    assign s_fr = FR'(r_si);
    assign s_pg = PG'(r_si - SI'(NF));
    assign safe_s = (32'(r_pframe[s_pg]) < NF) ? FR'(r_pframe[s_pg]) : '0;
    assign s_cnt = r_cnt[safe_s];
    assign safe_s_owner = (32'(r_pframe[r_owner]) < NF) ? FR'(r_pframe[r_owner]) : '0;

    assign o_sts.clr_done  = (r_clr == BA'(dpsu_pkg::BS_DEPTH - 1));
    assign o_sts.hit       = r_valid[r_page];
    assign o_sts.srch_done = r_empty_found || (r_si == SI'(NF + NP));
    // an owner exists only for a victim; both modes flag it in r_found
    assign o_sts.has_owner = !r_empty_found && r_found;
    assign o_sts.word_last = (r_w == OF'(PAGE_LAST));

    // empty test of the active mode
    function automatic logic is_empty(input logic [31:0] v);
        is_empty = (v == 32'hFFFF_FFFF);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_acc   <= '0;
            r_valid <= '0;
            r_dirty <= '0;
            r_clr   <= '0;
            for (int i = 0; i < NP; i++) r_pframe[i] <= PG'(i);
            for (int i = 0; i < NF; i++) begin
                r_cnt[i]   <= '1;
                r_stamp[i] <= '1;
            end
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + BA'(1);
            if (i_cfg_we) r_mode <= i_cfg_data;
            if (i_cmd.bump) r_acc <= r_acc + 32'd1;
            if (i_cmd.map) begin
                if (r_has_owner) begin
                    r_valid[r_owner]  <= 1'b0;
                    r_dirty[r_owner]  <= 1'b0;
                    r_pframe[r_owner] <= r_owner;
                end
                r_valid[r_page]  <= 1'b1;
                r_dirty[r_page]  <= 1'b0;
                r_pframe[r_page] <= PG'(r_frame);
                if (!r_mode) r_stamp[r_frame] <= r_acc;
                else if (!r_empty_found) r_cnt[r_frame] <= '0;
            end
            if (i_cmd.access) begin
                if (r_func) r_dirty[r_page] <= 1'b1;
                r_cnt[r_frame] <= r_cnt[r_frame] + 32'd1;
            end
        end
    end

    // search and copy control
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_func  <= i_item.func;
            r_page  <= PG'(i_item.virt_addr[5:3]);
            r_off   <= OF'(i_item.virt_addr[2:0]);
            r_wdata <= DB'(i_item.write_data);
            r_fault <= 1'b0;
        end
        if (i_cmd.srch_clr) begin
            r_si <= '0;
            r_empty_found <= 1'b0;
            r_found <= 1'b0;
            r_best <= '0;
            r_vfr <= '0;
            r_owner <= '0;
            r_frame <= safe_cur;
            r_w <= '0;
        end
        if (i_cmd.srch_step) begin
            r_fault <= 1'b1;
            r_si <= r_si + SI'(1);
            if (in_frames) begin
                if (!r_empty_found && is_empty(r_mode ? r_cnt[s_fr] : r_stamp[s_fr])) begin
                    r_empty_found <= 1'b1;
                    r_efr <= s_fr;
                end
                // FIFO: smallest stamp, ties to highest index
                if (s_fr == '0 || r_stamp[s_fr] <= r_best) begin
                    r_best <= r_stamp[s_fr];
                    r_vfr  <= s_fr;
                end
                if (r_si == SI'(NF - 1)) begin
                    r_found <= 1'b0;
                end
            end else if (!r_mode) begin
                if (!r_found && r_valid[s_pg] && FR'(r_pframe[s_pg]) == r_vfr
                        && 32'(r_pframe[s_pg]) < NF) begin
                    r_found <= 1'b1;
                    r_owner <= s_pg;
                end
            end else begin
                if (r_valid[s_pg] && (!r_found || s_cnt < r_best)) begin
                    r_found <= 1'b1;
                    r_best  <= s_cnt;
                    r_owner <= s_pg;
                end
            end
        end
        if (i_cmd.pick) begin
            r_w <= '0;
            if (r_empty_found) begin
                r_frame <= r_efr;
                r_has_owner <= 1'b0;
            end else if (!r_mode) begin
                r_frame <= r_vfr;
                r_has_owner <= r_found;
            end else begin
                r_frame <= r_found ? safe_s_owner : '0;
                r_has_owner <= r_found;
            end
        end
        if (i_cmd.wb_wr || i_cmd.ld_wr) r_w <= r_w + OF'(1);
        // on a write the RAM read returns old data; the written word is the result
        if (i_cmd.keep_word) r_res <= r_func ? r_wdata : fs_rd;
        if (i_cmd.capture) r_out <= '{read_data: 32'(r_res), page_fault: r_fault,
                                      frame_used: 2'(r_frame)};
    end

    // RAM ports: frame store read for writeback, written on load and access;
    // the clearing pass after reset fills both with all ones
    always_comb begin
        fs_a  = {r_frame, r_w};
        fs_we = i_cmd.ld_wr || (i_cmd.access && r_func);
        fs_wd = i_cmd.ld_wr ? bs_rd : r_wdata;
        bs_a  = {(i_cmd.wb_wr ? r_owner : r_page), r_w};
        bs_we = i_cmd.wb_wr;
        bs_wd = fs_rd;
        if (i_cmd.access) fs_a = {r_frame, r_off};
        if (i_cmd.clr) begin
            bs_a  = r_clr;
            bs_we = 1'b1;
            bs_wd = '1;
            fs_a  = r_clr[FA-1:0];
            fs_we = 1'b1;
            fs_wd = '1;
        end
    end

    dpsu_ram #(.WIDTH(DB), .DEPTH(dpsu_pkg::BS_DEPTH)) u_bs (
        .i_clk(i_clk), .i_we(bs_we), .i_addr(bs_a), .i_wdata(bs_wd), .o_rdata(bs_rd));
    dpsu_ram #(.WIDTH(DB), .DEPTH(dpsu_pkg::FS_DEPTH)) u_fs (
        .i_clk(i_clk), .i_we(fs_we), .i_addr(fs_a), .i_wdata(fs_wd), .o_rdata(fs_rd));

    always_comb begin
        o_item = r_out;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/demand_paging_swap_unit.sv =====
// Top level of the demand paging swap unit: controller plus datapath.
// Depends on dpsu_pkg, dpsu_ctrl, dpsu_dp (and dpsu_ram through dpsu_dp).
//
//  channel   direction  handshake          payload
//  in        input      i_in_valid/o_in_ready   dpsu_pkg::t_in_item
//  out       output     o_out_valid/i_out_ready dpsu_pkg::t_out_item
//  cfg       input      i_cfg_we (no wait)      i_cfg_data = replace_mode
//
// Hit: accept, lookup, access, read, output; the result is registered in the
// output step. Fault: the search stops at the first empty frame, else it walks
// all frames and pages; then pick, a writeback when a victim is evicted, and the
// page load. Each copied word takes a read state and a write state.
// Reset (synchronous, low) empties page table, counters and stamps, then a
// clearing pass writes all ones to both RAMs with o_in_ready low.
// One item at a time; a held result lets one more item run, then stalls it.
`default_nettype none
module demand_paging_swap_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire dpsu_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output dpsu_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_data
);
    dpsu_pkg::t_cmd cmd;
    dpsu_pkg::t_sts sts;

    dpsu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(sts), .o_cmd(cmd));

    dpsu_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_item(i_in_item), .i_cmd(cmd), .o_sts(sts), .o_item(o_out_item));
endmodule
`default_nettype wire
